/* rtl/nalt_pkg.sv */
// ----------------------------------------------------------------------------
// nalt_pkg: shared types and constants for the nearest angle table lookup
// Widths, command and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package nalt_pkg;

  localparam int TableEntries = 16;
  localparam int IdxW         = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int CntW         = $clog2(TableEntries + 1);
  localparam int KeyW         = 9;
  localparam int IdW          = 16;
  localparam int AngleW       = 32;
  localparam int CmdW         = 2;
  localparam int StatW        = 2;
  localparam int FullCircle   = 360;
  localparam int RedBits      = 8;
  localparam int RedSteps     = AngleW / RedBits;
  localparam int CtrW         = (IdxW > $clog2(RedSteps)) ? IdxW : $clog2(RedSteps);

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PUT   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic            load;
    logic            red_step;
    logic            scan_step;
    logic [IdxW-1:0] idx;
    logic            resolve;
    logic            out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_scan;
  } dp_stat_t;

endpackage

/* rtl/nalt_if.sv */
// ----------------------------------------------------------------------------
// nalt_if: request and result channels of the nearest angle table lookup
// Valid/ready handshake with the payload fields of each direction.
// ----------------------------------------------------------------------------
interface nalt_in_if;
  logic                            valid;
  logic                            ready;
  logic [nalt_pkg::CmdW-1:0]       command;
  logic [nalt_pkg::AngleW-1:0]     angle_value;
  logic [nalt_pkg::IdW-1:0]        entry_id;

  modport source (output valid, command, angle_value, entry_id, input ready);
  modport sink   (input valid, command, angle_value, entry_id, output ready);
endinterface

interface nalt_out_if;
  logic                            valid;
  logic                            ready;
  logic [nalt_pkg::StatW-1:0]      status;
  logic [nalt_pkg::IdW-1:0]        matched_id;

  modport source (output valid, status, matched_id, input ready);
  modport sink   (input valid, status, matched_id, output ready);
endinterface

/* rtl/nalt_ctrl.sv */
// ----------------------------------------------------------------------------
// nalt_ctrl: sequencer of the nearest angle table lookup
// Steps each request through reduction, table scan (put and query), resolve and delivery.
// ----------------------------------------------------------------------------
module nalt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  nalt_pkg::dp_stat_t dp_stat,
  output nalt_pkg::dp_cmd_t  dp_cmd
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_REDUCE  = 5'b00010,
    S_SCAN    = 5'b00100,
    S_RESOLVE = 5'b01000,
    S_DONE    = 5'b10000
  } state_t;

  localparam logic [nalt_pkg::CtrW-1:0] RedLast  = nalt_pkg::CtrW'(nalt_pkg::RedSteps - 1);
  localparam logic [nalt_pkg::CtrW-1:0] ScanLast =
    nalt_pkg::CtrW'(nalt_pkg::TableEntries - 1);

  state_t                      state_r, state_nxt;
  logic [nalt_pkg::CtrW-1:0]   cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    dp_cmd        = '0;

    // drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = S_REDUCE;
        end
      end
      S_REDUCE: begin
        dp_cmd.red_step = 1'b1;
        if (cnt_r == RedLast) begin
          cnt_nxt   = '0;
          state_nxt = dp_stat.needs_scan ? S_SCAN : S_RESOLVE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SCAN: begin
        dp_cmd.scan_step = 1'b1;
        if (cnt_r == ScanLast) begin
          state_nxt = S_RESOLVE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RESOLVE: begin
        dp_cmd.resolve = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          dp_cmd.out_load = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // address the entry scanned in the next cycle
    dp_cmd.idx = cnt_nxt[nalt_pkg::IdxW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/nalt_dp.sv */
// ----------------------------------------------------------------------------
// nalt_dp: datapath of the nearest angle table lookup
// Angle reduction, entry table, scan accumulators, resolve and result register.
// ----------------------------------------------------------------------------
module nalt_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nalt_pkg::dp_cmd_t             dp_cmd,
  output nalt_pkg::dp_stat_t            dp_stat,
  input  logic [nalt_pkg::CmdW-1:0]     in_command,
  input  logic [nalt_pkg::AngleW-1:0]   in_angle_value,
  input  logic [nalt_pkg::IdW-1:0]      in_entry_id,
  output logic [nalt_pkg::StatW-1:0]    out_status,
  output logic [nalt_pkg::IdW-1:0]      out_matched_id
);

  localparam int KeyW = nalt_pkg::KeyW;
  localparam int IdW  = nalt_pkg::IdW;
  localparam logic [KeyW:0] Circle = (KeyW + 1)'(nalt_pkg::FullCircle);

  // request registers
  nalt_pkg::cmd_t                cmd_r;
  logic [IdW-1:0]                id_in_r;
  logic [nalt_pkg::AngleW-1:0]   ang_r;
  logic [KeyW-1:0]               rem_r;

  // entry table
  logic [nalt_pkg::TableEntries-1:0] valid_r;
  logic [KeyW-1:0]                   key_mem [nalt_pkg::TableEntries];
  logic [IdW-1:0]                    id_mem  [nalt_pkg::TableEntries];
  logic [nalt_pkg::CntW-1:0]         count_r;

  // scan accumulators
  logic                        have_any_r, have_pred_r, have_succ_r, hit_r, free_r;
  logic [KeyW-1:0]             min_k_r, max_k_r, pred_k_r, succ_k_r;
  logic [IdW-1:0]              min_i_r, max_i_r, pred_i_r, succ_i_r;
  logic [nalt_pkg::IdxW-1:0]   hit_idx_r, free_idx_r;

  // resolve and output
  nalt_pkg::status_t           res_status, res_status_r;
  logic [IdW-1:0]              res_id, res_id_r;
  logic [nalt_pkg::StatW-1:0]  out_status_r;
  logic [IdW-1:0]              out_id_r;

  // reduction step: eight restoring compare-subtracts
  logic [KeyW-1:0]             red_rem;
  logic [KeyW:0]               red_t;

  always_comb begin
    red_rem = rem_r;
    red_t   = '0;
    for (int j = 0; j < nalt_pkg::RedBits; j++) begin
      red_t = {red_rem, ang_r[nalt_pkg::AngleW-1-j]};
      if (red_t >= Circle) begin
        red_t = red_t - Circle;
      end
      red_rem = red_t[KeyW-1:0];
    end
  end

  assign dp_stat.needs_scan = (cmd_r == nalt_pkg::CMD_PUT) || (cmd_r == nalt_pkg::CMD_QUERY);

  // entry under scan
  logic                      sc_v;
  logic [nalt_pkg::IdxW-1:0] sc_idx_r;
  logic [KeyW-1:0]           sc_k_r;
  logic [IdW-1:0]            sc_i_r;

  // fetch the entry addressed for the next cycle
  always_ff @(posedge clk) begin
    sc_idx_r <= dp_cmd.idx;
    sc_k_r   <= key_mem[dp_cmd.idx];
    sc_i_r   <= id_mem[dp_cmd.idx];
  end

  assign sc_v = valid_r[sc_idx_r];

  // final selection
  logic [KeyW:0] ud, ld;
  logic          pick_min;

  always_comb begin
    ud         = '0;
    ld         = '0;
    pick_min   = 1'b0;
    res_status = nalt_pkg::STAT_OK;
    res_id     = '0;
    if (!have_succ_r) begin
      // every key at or below the angle: last key vs first key wrapped forward
      ud = {1'b0, rem_r} - {1'b0, max_k_r};
      ld = Circle - {1'b0, rem_r} + {1'b0, min_k_r};
    end else if (!have_pred_r) begin
      // every key above the angle: first key vs last key wrapped backward
      ld = {1'b0, min_k_r} - {1'b0, rem_r};
      ud = Circle - {1'b0, max_k_r} + {1'b0, rem_r};
    end else begin
      ud = {1'b0, succ_k_r} - {1'b0, rem_r};
      ld = {1'b0, rem_r} - {1'b0, pred_k_r};
    end
    pick_min = (ud > ld);

    unique case (cmd_r)
      nalt_pkg::CMD_PUT: begin
        if (!hit_r && !free_r) begin
          res_status = nalt_pkg::STAT_FULL;
        end
      end
      nalt_pkg::CMD_QUERY: begin
        if (count_r == '0) begin
          res_status = nalt_pkg::STAT_EMPTY;
        end else if (count_r == nalt_pkg::CntW'(1)) begin
          res_id = min_i_r;
        end else if (!have_succ_r || !have_pred_r) begin
          res_id = pick_min ? min_i_r : max_i_r;
        end else begin
          res_id = (ud <= ld) ? succ_i_r : pred_i_r;
        end
      end
      default: begin
        res_status = nalt_pkg::STAT_OK;
      end
    endcase
  end

  // control flags, valid bits and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      count_r     <= '0;
      have_any_r  <= 1'b0;
      have_pred_r <= 1'b0;
      have_succ_r <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
    end else begin
      if (dp_cmd.load) begin
        have_any_r  <= 1'b0;
        have_pred_r <= 1'b0;
        have_succ_r <= 1'b0;
        hit_r       <= 1'b0;
        free_r      <= 1'b0;
      end
      if (dp_cmd.scan_step) begin
        if (sc_v) begin
          have_any_r <= 1'b1;
          if (sc_k_r == rem_r) begin
            hit_r <= 1'b1;
          end
          if (sc_k_r <= rem_r) begin
            have_pred_r <= 1'b1;
          end else begin
            have_succ_r <= 1'b1;
          end
        end else if (!free_r) begin
          free_r <= 1'b1;
        end
      end
      if (dp_cmd.resolve) begin
        if (cmd_r == nalt_pkg::CMD_CLEAR) begin
          valid_r <= '0;
          count_r <= '0;
        end else if (cmd_r == nalt_pkg::CMD_PUT && !hit_r && free_r) begin
          valid_r[free_idx_r] <= 1'b1;
          count_r             <= count_r + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r   <= nalt_pkg::cmd_t'(in_command);
      id_in_r <= in_entry_id;
      ang_r   <= in_angle_value;
      rem_r   <= '0;
    end
    if (dp_cmd.red_step) begin
      rem_r <= red_rem;
      ang_r <= ang_r << nalt_pkg::RedBits;
    end
    if (dp_cmd.scan_step) begin
      if (sc_v) begin
        if (sc_k_r == rem_r) begin
          hit_idx_r <= sc_idx_r;
        end
        if (!have_any_r || sc_k_r < min_k_r) begin
          min_k_r <= sc_k_r;
          min_i_r <= sc_i_r;
        end
        if (!have_any_r || sc_k_r > max_k_r) begin
          max_k_r <= sc_k_r;
          max_i_r <= sc_i_r;
        end
        if (sc_k_r <= rem_r) begin
          if (!have_pred_r || sc_k_r > pred_k_r) begin
            pred_k_r <= sc_k_r;
            pred_i_r <= sc_i_r;
          end
        end else begin
          if (!have_succ_r || sc_k_r < succ_k_r) begin
            succ_k_r <= sc_k_r;
            succ_i_r <= sc_i_r;
          end
        end
      end else if (!free_r) begin
        free_idx_r <= sc_idx_r;
      end
    end
    if (dp_cmd.resolve) begin
      res_status_r <= res_status;
      res_id_r     <= res_id;
      if (cmd_r == nalt_pkg::CMD_PUT) begin
        if (hit_r) begin
          id_mem[hit_idx_r] <= id_in_r;
        end else if (free_r) begin
          key_mem[free_idx_r] <= rem_r;
          id_mem[free_idx_r]  <= id_in_r;
        end
      end
    end
    if (dp_cmd.out_load) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
    end
  end

  assign out_status     = out_status_r;
  assign out_matched_id = out_id_r;

endmodule

/* rtl/nearest_angle_table_lookup.sv */
// ----------------------------------------------------------------------------
// nearest_angle_table_lookup: circular nearest-key table
// Stores (angle key, id) pairs and answers a query angle with the id of the
// circularly nearest key; clear and put maintain the table.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake         payload
//  --------  ---  ----------------  ------------------------------------------
//  in_ch     in   valid / ready     command[1:0], angle_value[31:0], entry_id[15:0]
//  out_ch    out  valid / ready     status[1:0], matched_id[15:0]
//
//  Put and query requests pass from one accept to the next through an idle
//  state, mod-360 reduction (8 angle bits a cycle), a table scan (one entry a
//  cycle over the 16-entry table), resolve and load. Clear and the unused
//  command skip the scan.
//  Reset (rst_n, synchronous, active low) invalidates every table entry at once.
//  A stalled result holds in the output register; the sequencer waits before
//  loading the next one, and no new request is taken until then.
//
module nearest_angle_table_lookup (
  input  logic       clk,
  input  logic       rst_n,
  nalt_in_if.sink    in_ch,
  nalt_out_if.source out_ch
);

  nalt_pkg::dp_cmd_t  dp_cmd;
  nalt_pkg::dp_stat_t dp_stat;

  // sequencer: handshakes and step commands
  nalt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  // datapath: reduction, table, scan and result register
  nalt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .dp_cmd         (dp_cmd),
    .dp_stat        (dp_stat),
    .in_command     (in_ch.command),
    .in_angle_value (in_ch.angle_value),
    .in_entry_id    (in_ch.entry_id),
    .out_status     (out_ch.status),
    .out_matched_id (out_ch.matched_id)
  );

endmodule

/* test/tb_nearest_angle_table_lookup.sv */
// ----------------------------------------------------------------------------
// tb_nearest_angle_table_lookup: self-checking bench for the angle table
// Drives clear, put and query requests through the valid/ready request
// channel, predicts each answer with a table model of its own and compares
// every returned status and id in order, with random idling on both sides in part of the run.
// ----------------------------------------------------------------------------
module tb_nearest_angle_table_lookup;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 40;     // a bit over one request's full turnaround
  localparam int RandomItems  = 600;

  typedef struct {
    nalt_pkg::cmd_t                  command;
    logic [nalt_pkg::AngleW-1:0]     angle;
    logic [nalt_pkg::IdW-1:0]        entry_id;
    bit                              drain_first;  // hold until all answers are back
  } lookup_request_t;

  typedef struct {
    nalt_pkg::status_t          status;
    logic [nalt_pkg::IdW-1:0]   matched_id;
  } lookup_answer_t;

  logic clk;
  logic rst_n;

  nalt_in_if  in_ch();
  nalt_out_if out_ch();

  nearest_angle_table_lookup uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Requests waiting to be driven, and answers waiting to come back.
  lookup_request_t pending_requests[$];
  lookup_answer_t  awaited_answers[$];
  lookup_request_t current_request;

  // Shadow copy of the angle table.
  logic [nalt_pkg::KeyW-1:0] slot_key [nalt_pkg::TableEntries];
  logic [nalt_pkg::IdW-1:0]  slot_id  [nalt_pkg::TableEntries];
  bit                        slot_used[nalt_pkg::TableEntries] = '{default: 1'b0};

  int requests_issued = 0;
  int results_seen    = 0;
  int stimulus_total  = 0;
  int failures        = 0;
  int cycle_count     = 0;

  // Clock, reset and known values on every input from time zero.
  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.command     = nalt_pkg::CMD_NONE;
    in_ch.angle_value = '0;
    in_ch.entry_id    = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    forever #1 clk = ~clk;
  end

  // Apply one request to the shadow table and return the answer it causes.
  function automatic lookup_answer_t apply_request(lookup_request_t req);
    lookup_answer_t           ans;
    int                       w, n, k, lo_k, hi_k, pred_k, succ_k, up_d, dn_d;
    logic [nalt_pkg::IdW-1:0] lo_id, hi_id, pred_id, succ_id;
    bit                       has_pred, has_succ, stored;
    w = int'(req.angle % nalt_pkg::FullCircle);
    ans.status     = nalt_pkg::STAT_OK;
    ans.matched_id = '0;
    case (req.command)
      nalt_pkg::CMD_CLEAR: begin
        foreach (slot_used[i]) slot_used[i] = 1'b0;
      end
      nalt_pkg::CMD_PUT: begin
        stored = 1'b0;
        // overwrite an existing key first, otherwise take the lowest free slot
        for (int i = 0; i < nalt_pkg::TableEntries; i++) begin
          if (!stored && slot_used[i] && int'(slot_key[i]) == w) begin
            slot_id[i] = req.entry_id;
            stored     = 1'b1;
          end
        end
        for (int i = 0; i < nalt_pkg::TableEntries; i++) begin
          if (!stored && !slot_used[i]) begin
            slot_used[i] = 1'b1;
            slot_key[i]  = nalt_pkg::KeyW'(w);
            slot_id[i]   = req.entry_id;
            stored       = 1'b1;
          end
        end
        if (!stored) ans.status = nalt_pkg::STAT_FULL;
      end
      nalt_pkg::CMD_QUERY: begin
        n = 0;
        has_pred = 1'b0;
        has_succ = 1'b0;
        lo_k = nalt_pkg::FullCircle;
        hi_k = -1;
        pred_k = 0;
        succ_k = 0;
        lo_id = '0;
        hi_id = '0;
        pred_id = '0;
        succ_id = '0;
        for (int i = 0; i < nalt_pkg::TableEntries; i++) begin
          if (slot_used[i]) begin
            k = int'(slot_key[i]);
            n++;
            if (k < lo_k) begin
              lo_k  = k;
              lo_id = slot_id[i];
            end
            if (k > hi_k) begin
              hi_k  = k;
              hi_id = slot_id[i];
            end
            if (k <= w) begin
              if (!has_pred || k > pred_k) begin
                pred_k   = k;
                pred_id  = slot_id[i];
                has_pred = 1'b1;
              end
            end else if (!has_succ || k < succ_k) begin
              succ_k   = k;
              succ_id  = slot_id[i];
              has_succ = 1'b1;
            end
          end
        end
        if (n == 0) begin
          ans.status = nalt_pkg::STAT_EMPTY;
        end else if (n == 1) begin
          ans.matched_id = lo_id;
        end else if (!has_succ) begin
          // every key at or below the angle: last key against first key wrapped
          up_d = w - hi_k;
          dn_d = nalt_pkg::FullCircle - w + lo_k;
          ans.matched_id = (up_d > dn_d) ? lo_id : hi_id;
        end else if (!has_pred) begin
          // every key above the angle: first key against last key wrapped back
          dn_d = lo_k - w;
          up_d = nalt_pkg::FullCircle - hi_k + w;
          ans.matched_id = (up_d > dn_d) ? lo_id : hi_id;
        end else begin
          // between two neighbors, a tie goes to the upper one
          up_d = succ_k - w;
          dn_d = w - pred_k;
          ans.matched_id = (up_d <= dn_d) ? succ_id : pred_id;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic add_request(nalt_pkg::cmd_t c, logic [nalt_pkg::AngleW-1:0] a,
                             logic [nalt_pkg::IdW-1:0] id, bit drain = 1'b0);
    lookup_request_t req;
    req.command     = c;
    req.angle       = a;
    req.entry_id    = id;
    req.drain_first = drain;
    pending_requests.push_back(req);
  endtask

  // Idling runs in three thirds of the run: sender light and receiver heavy,
  // then the reverse, then no idling at all.
  function automatic int run_third();
    return (stimulus_total == 0) ? 0 : (requests_issued * 3) / stimulus_total;
  endfunction

  function automatic int sender_idle_pct();
    case (run_third())
      0:       return 13;
      1:       return 55;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (run_third())
      0:       return 55;
      1:       return 13;
      default: return 0;
    endcase
  endfunction

  // Request driver: predict on accept, hold a request until taken, then
  // advance to the next pending one unless the sender idles this cycle.
  always @(posedge clk) begin : request_driver
    bit busy, taken, send;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      taken = in_ch.valid && in_ch.ready;
      busy  = in_ch.valid && !taken;
      send  = 1'b0;
      if (taken) begin
        awaited_answers.push_back(apply_request(current_request));
        requests_issued <= requests_issued + 1;
      end
      if (!busy && pending_requests.size() > 0 &&
          $urandom_range(99) >= sender_idle_pct()) begin
        // a drain request waits until every answer so far has come back
        send = !pending_requests[0].drain_first ||
               (!taken && requests_issued == results_seen);
      end
      if (send) begin
        current_request = pending_requests.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.command     <= current_request.command;
        in_ch.angle_value <= current_request.angle;
        in_ch.entry_id    <= current_request.entry_id;
      end else if (!busy) begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Answer monitor: check every accepted answer against the oldest prediction.
  always @(posedge clk) begin : answer_monitor
    lookup_answer_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (awaited_answers.size() == 0) begin
          $error("answer with no request outstanding: status %0d, matched_id %0h",
                 out_ch.status, out_ch.matched_id);
          failures++;
        end else begin
          want = awaited_answers.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_ch.status);
            failures++;
          end
          if (out_ch.matched_id !== want.matched_id) begin
            $error("matched_id mismatch: expected %0h, got %0h",
                   want.matched_id, out_ch.matched_id);
            failures++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [nalt_pkg::AngleW-1:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return nalt_pkg::AngleW'($urandom_range(35) * 10);   // ties at midpoints
    if (roll < 85) return nalt_pkg::AngleW'($urandom_range(nalt_pkg::FullCircle - 1));
    return $urandom();
  endfunction

  function automatic logic [nalt_pkg::AngleW-1:0] pick_angle();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return nalt_pkg::AngleW'($urandom_range(71) * 5);
    if (roll < 75) return nalt_pkg::AngleW'($urandom_range(nalt_pkg::FullCircle - 1));
    return $urandom();
  endfunction

  initial begin : stimulus
    int fill_n, query_n, made;
    // Directed: empty table, single entry, exact hit, key reduction, overwrite.
    add_request(nalt_pkg::CMD_QUERY, 32'd0, 16'h0000);
    add_request(nalt_pkg::CMD_QUERY, 32'hFFFF_FFFF, 16'hFFFF);
    add_request(nalt_pkg::CMD_PUT, 32'd359, 16'hFFFF);
    add_request(nalt_pkg::CMD_QUERY, 32'h1234_5678, 16'h0000);
    add_request(nalt_pkg::CMD_PUT, 32'd360, 16'h0001);          // lands on key 0
    add_request(nalt_pkg::CMD_QUERY, 32'd0, 16'h0000);
    add_request(nalt_pkg::CMD_QUERY, 32'd180, 16'h0000);
    add_request(nalt_pkg::CMD_PUT, 32'hFFFF_FFFF, 16'h8000);    // reduces to key 255
    add_request(nalt_pkg::CMD_PUT, 32'd255, 16'h7FFF);          // overwrite
    add_request(nalt_pkg::CMD_NONE, 32'hA5A5_5A5A, 16'hBEEF);
    add_request(nalt_pkg::CMD_CLEAR, 32'd77, 16'h0000);
    // Ties across the wrap and between neighbors.
    add_request(nalt_pkg::CMD_PUT, 32'd10, 16'h00AA);
    add_request(nalt_pkg::CMD_PUT, 32'd350, 16'h0055);
    add_request(nalt_pkg::CMD_QUERY, 32'd0, 16'h0000);
    add_request(nalt_pkg::CMD_QUERY, 32'd180, 16'h0000);
    add_request(nalt_pkg::CMD_QUERY, 32'd355, 16'h0000);
    add_request(nalt_pkg::CMD_QUERY, 32'd5, 16'h0000);
    add_request(nalt_pkg::CMD_PUT, 32'd100, 16'h1234);
    add_request(nalt_pkg::CMD_QUERY, 32'd55, 16'h0000);
    // Fill the table, then a new key is refused and an existing one still lands.
    for (int i = 1; i <= nalt_pkg::TableEntries - 3; i++) begin
      add_request(nalt_pkg::CMD_PUT, nalt_pkg::AngleW'(20 * i + 5),
                  nalt_pkg::IdW'($urandom()));
    end
    add_request(nalt_pkg::CMD_PUT, 32'd300, 16'h4321);
    add_request(nalt_pkg::CMD_PUT, 32'd350, 16'hC3C3);
    add_request(nalt_pkg::CMD_QUERY, 32'd300, 16'h0000, 1'b1);

    // Random: mostly a clear, a burst of puts, then queries with a few
    // late puts mixed in; now and then noise in place of the clear.
    made = 0;
    while (made < RandomItems) begin
      if ($urandom_range(9) == 0) begin
        add_request(nalt_pkg::CMD_NONE, $urandom(), nalt_pkg::IdW'($urandom()));
      end else begin
        add_request(nalt_pkg::CMD_CLEAR, $urandom(), nalt_pkg::IdW'($urandom()));
      end
      made++;
      fill_n = $urandom_range(nalt_pkg::TableEntries + 4);
      for (int i = 0; i < fill_n; i++) begin
        add_request(nalt_pkg::CMD_PUT, pick_key(), nalt_pkg::IdW'($urandom()));
      end
      made += fill_n;
      query_n = $urandom_range(16, 4);
      for (int i = 0; i < query_n; i++) begin
        if ($urandom_range(9) < 2) begin
          add_request(nalt_pkg::CMD_PUT, pick_key(), nalt_pkg::IdW'($urandom()));
        end else begin
          add_request(nalt_pkg::CMD_QUERY, pick_angle(), nalt_pkg::IdW'($urandom()),
                      (made + i) % 200 == 0);
        end
      end
      made += query_n;
    end
    stimulus_total = pending_requests.size();

    // Every request causes exactly one answer; wait for all, then settle.
    while (results_seen != stimulus_total) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (awaited_answers.size() != 0) begin
      $error("%0d answers never arrived", awaited_answers.size());
      failures++;
    end
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
